>>> rtl/i2cms_pkg.sv
package i2cms_pkg;

  localparam int MAX_MESSAGES_DEF = 8;
  localparam int PAYLOAD_AW_DEF   = 8;
  localparam int CHANNELS_DEF     = 4;

  localparam logic [2:0] OP_LOAD_MSG  = 3'd0;
  localparam logic [2:0] OP_LOAD_BYTE = 3'd1;
  localparam logic [2:0] OP_BEGIN     = 3'd2;
  localparam logic [2:0] OP_BYTE_DONE = 3'd3;
  localparam logic [2:0] OP_BUS_ERROR = 3'd4;

  localparam logic [1:0] END_RUN   = 2'd0;
  localparam logic [1:0] END_STOP  = 2'd1;
  localparam logic [1:0] END_ABORT = 2'd2;

  typedef struct packed {
    logic [2:0] operation;
    logic [1:0] channel;
    logic [6:0] target_address;
    logic       read_flag;
    logic       no_start_flag;
    logic       no_read_ack_flag;
    logic [7:0] length;
    logic [7:0] data_byte;
  } item_in_t;

  typedef struct packed {
    logic       issue_command;
    logic       send_start;
    logic       send_stop;
    logic       direction_read;
    logic       ack_enable;
    logic [1:0] bus_channel;
    logic [7:0] transmit_byte;
    logic       capture_valid;
    logic [7:0] capture_byte;
    logic [7:0] capture_position;
    logic [1:0] end_status;
    logic [3:0] messages_done;
  } item_out_t;

  typedef struct packed {
    logic latch;
    logic load_msg;
    logic load_byte;
    logic begin_xfer;
    logic end_req;
    logic end_abort;
    logic end_zero;
    logic start_cmd;
    logic read_cmd;
    logic write_cmd;
    logic capture;
    logic next_msg;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       chan_ok;
    logic       can_load;
    logic       list_empty;
    logic       at_len;
    logic       cur_read;
    logic       cur_nostart;
    logic       left_zero;
  } dp_stat_t;

endpackage

>>> rtl/i2cms_ram.sv
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/i2cms_datapath.sv
module i2cms_datapath #(
  parameter int MAX_MESSAGES = i2cms_pkg::MAX_MESSAGES_DEF,
  parameter int PAYLOAD_AW   = i2cms_pkg::PAYLOAD_AW_DEF,
  parameter int CHANNELS     = i2cms_pkg::CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2cms_pkg::item_in_t   in_item_i,
  input  i2cms_pkg::dp_cmd_t    cmd_i,
  output i2cms_pkg::dp_stat_t   stat_o,
  output i2cms_pkg::item_out_t  out_item_o
);

  localparam int CW = $clog2(MAX_MESSAGES + 1);
  localparam int IW = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
  localparam int AW = PAYLOAD_AW;

  i2cms_pkg::item_in_t  item_q;
  i2cms_pkg::item_out_t res_q, out_q;

  logic [6:0]    maddr_q [MAX_MESSAGES];
  logic [2:0]    mflags_q [MAX_MESSAGES];
  logic [7:0]    mlen_q [MAX_MESSAGES];
  logic [AW-1:0] moff_q [MAX_MESSAGES];

  logic [CW-1:0] loaded_q, loaded_d, left_q, left_d, cur_q, cur_d;
  logic [AW-1:0] lp_q, lp_d;
  logic [7:0]    bp_q, bp_d;
  logic [1:0]    chan_q, chan_d;

  logic [IW-1:0] cur_idx, ld_idx;
  logic [AW-1:0] pos, ram_addr;
  logic [7:0]    ram_rdata;
  logic [2:0]    cflags;

  assign cur_idx = (cur_q < CW'(MAX_MESSAGES)) ? cur_q[IW-1:0] : '0;
  assign ld_idx  = loaded_q[IW-1:0];
  assign cflags  = mflags_q[cur_idx];
  assign pos     = moff_q[cur_idx] + AW'(bp_q);
  assign ram_addr = cmd_i.load_byte ? lp_q : pos;

  i2cms_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_byte | cmd_i.capture),
    .addr_i  (ram_addr),
    .wdata_i (item_q.data_byte),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    stat_o.op          = item_q.operation;
    stat_o.chan_ok     = 32'(item_q.channel) < CHANNELS;
    stat_o.can_load    = loaded_q < CW'(MAX_MESSAGES);
    stat_o.list_empty  = loaded_q == '0;
    stat_o.at_len      = bp_q == mlen_q[cur_idx];
    stat_o.cur_read    = cflags[0];
    stat_o.cur_nostart = cflags[1];
    stat_o.left_zero   = left_q == '0;
  end

  always_comb begin
    loaded_d = loaded_q;
    left_d   = left_q;
    cur_d    = cur_q;
    lp_d     = lp_q;
    bp_d     = bp_q;
    chan_d   = chan_q;
    if (cmd_i.load_msg) begin
      loaded_d = loaded_q + CW'(1);
      if (item_q.read_flag) begin
        lp_d = lp_q + AW'(item_q.length);
      end
    end
    if (cmd_i.load_byte) begin
      lp_d = lp_q + AW'(1);
    end
    if (cmd_i.begin_xfer) begin
      cur_d  = '0;
      bp_d   = '0;
      left_d = loaded_q;
      chan_d = item_q.channel;
    end
    if (cmd_i.write_cmd || cmd_i.capture) begin
      bp_d = bp_q + 8'd1;
    end
    if (cmd_i.next_msg) begin
      bp_d  = '0;
      cur_d = cur_q + CW'(1);
      if (left_q != '0) begin
        left_d = left_q - CW'(1);
      end
    end
    if (cmd_i.end_req) begin
      loaded_d = '0;
      lp_d     = '0;
      cur_d    = '0;
      left_d   = '0;
      bp_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      left_q   <= '0;
      cur_q    <= '0;
      lp_q     <= '0;
      bp_q     <= '0;
      chan_q   <= '0;
    end else begin
      loaded_q <= loaded_d;
      left_q   <= left_d;
      cur_q    <= cur_d;
      lp_q     <= lp_d;
      bp_q     <= bp_d;
      chan_q   <= chan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_item_i;
    end
    if (cmd_i.load_msg) begin
      maddr_q[ld_idx]  <= item_q.target_address;
      mflags_q[ld_idx] <= {item_q.no_read_ack_flag, item_q.no_start_flag, item_q.read_flag};
      mlen_q[ld_idx]   <= item_q.length;
      moff_q[ld_idx]   <= lp_q;
    end
    if (cmd_i.publish) begin
      out_q <= res_q;
    end
    if (cmd_i.latch) begin
      res_q <= '0;
    end else begin
      if (cmd_i.end_req) begin
        res_q.end_status    <= cmd_i.end_abort ? i2cms_pkg::END_ABORT : i2cms_pkg::END_STOP;
        res_q.messages_done <= cmd_i.end_zero ? 4'd0 : 4'(loaded_q - left_q);
      end
      if (cmd_i.start_cmd) begin
        res_q.issue_command <= 1'b1;
        res_q.send_start    <= 1'b1;
        res_q.send_stop     <= stat_o.at_len;
        res_q.bus_channel   <= chan_q;
        res_q.transmit_byte <= {maddr_q[cur_idx], cflags[0]};
      end
      if (cmd_i.read_cmd) begin
        res_q.issue_command  <= 1'b1;
        res_q.direction_read <= 1'b1;
        res_q.ack_enable     <= ~cflags[2];
        res_q.bus_channel    <= chan_q;
      end
      if (cmd_i.write_cmd) begin
        res_q.issue_command <= 1'b1;
        res_q.send_stop     <= (bp_q + 8'd1) == mlen_q[cur_idx];
        res_q.bus_channel   <= chan_q;
        res_q.transmit_byte <= ram_rdata;
      end
      if (cmd_i.capture) begin
        res_q.capture_valid    <= 1'b1;
        res_q.capture_byte     <= item_q.data_byte;
        res_q.capture_position <= 8'(pos);
      end
    end
  end

  assign out_item_o = out_q;

endmodule

>>> rtl/i2cms_ctrl.sv
module i2cms_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  i2cms_pkg::dp_stat_t stat_i,
  output i2cms_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_READY    = 8'b00000001,
    S_DISPATCH = 8'b00000010,
    S_BEGIN2   = 8'b00000100,
    S_RSTEP    = 8'b00001000,
    S_WSTEP    = 8'b00010000,
    S_WFETCH   = 8'b00100000,
    S_NEXT     = 8'b01000000,
    S_EMIT     = 8'b10000000
  } state_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_WRITE = 4'b0100,
    PH_READ  = 4'b1000
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      S_READY: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_EMIT;
        case (stat_i.op)
          i2cms_pkg::OP_LOAD_MSG: begin
            cmd_o.load_msg = (phase_q == PH_IDLE) && stat_i.can_load;
          end
          i2cms_pkg::OP_LOAD_BYTE: begin
            cmd_o.load_byte = phase_q == PH_IDLE;
          end
          i2cms_pkg::OP_BEGIN: begin
            if (phase_q == PH_IDLE) begin
              if (!stat_i.chan_ok) begin
                cmd_o.end_req   = 1'b1;
                cmd_o.end_abort = 1'b1;
                cmd_o.end_zero  = 1'b1;
              end else if (stat_i.list_empty) begin
                cmd_o.end_req  = 1'b1;
                cmd_o.end_zero = 1'b1;
              end else begin
                cmd_o.begin_xfer = 1'b1;
                state_d = S_BEGIN2;
              end
            end
          end
          i2cms_pkg::OP_BYTE_DONE: begin
            if (phase_q == PH_START) begin
              phase_d = stat_i.cur_read ? PH_READ : PH_WRITE;
              state_d = stat_i.cur_read ? S_RSTEP : S_WSTEP;
            end else if (phase_q == PH_WRITE) begin
              state_d = S_WSTEP;
            end else if (phase_q == PH_READ) begin
              cmd_o.capture = 1'b1;
              state_d = S_RSTEP;
            end
          end
          i2cms_pkg::OP_BUS_ERROR: begin
            if (phase_q != PH_IDLE) begin
              cmd_o.end_req   = 1'b1;
              cmd_o.end_abort = 1'b1;
              phase_d = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      S_BEGIN2: begin
        cmd_o.start_cmd = 1'b1;
        phase_d = PH_START;
        state_d = S_EMIT;
      end
      S_RSTEP: begin
        if (!stat_i.at_len) begin
          cmd_o.read_cmd = 1'b1;
          state_d = S_EMIT;
        end else begin
          cmd_o.next_msg = 1'b1;
          state_d = S_NEXT;
        end
      end
      S_WSTEP: begin
        if (!stat_i.at_len) begin
          state_d = S_WFETCH;
        end else begin
          cmd_o.next_msg = 1'b1;
          state_d = S_NEXT;
        end
      end
      S_WFETCH: begin
        cmd_o.write_cmd = 1'b1;
        state_d = S_EMIT;
      end
      S_NEXT: begin
        state_d = S_EMIT;
        if (stat_i.left_zero) begin
          cmd_o.end_req = 1'b1;
          phase_d = PH_IDLE;
        end else if (!stat_i.cur_nostart) begin
          cmd_o.start_cmd = 1'b1;
          phase_d = PH_START;
        end else if ((phase_q == PH_READ) != stat_i.cur_read) begin
          // continuation that switches direction ends the transfer
          cmd_o.end_req = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          state_d = (phase_q == PH_READ) ? S_RSTEP : S_WSTEP;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.publish = 1'b1;
          state_d = S_READY;
        end
      end
      default: state_d = S_READY;
    endcase
  end

  assign out_valid_d = cmd_o.publish | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_READY;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_READY;
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/i2c_message_sequencer.sv
// one item at a time: accept, dispatch, optional steps, then the result moves to the
// output register; loads, errors and early-ending begins go straight to emit; a begin
// that starts adds S_BEGIN2, a read S_RSTEP, a write S_WSTEP+S_WFETCH, a next message S_NEXT
// the next item is taken while a finished result still waits in the output register
// payload bytes live in a single-port ram; a write byte waits in S_WFETCH for its read
// reset clears all control state and empties the message list; the ram is not cleared
module i2c_message_sequencer #(
  parameter int MAX_MESSAGES = i2cms_pkg::MAX_MESSAGES_DEF,
  parameter int PAYLOAD_AW   = i2cms_pkg::PAYLOAD_AW_DEF,
  parameter int CHANNELS     = i2cms_pkg::CHANNELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  i2cms_pkg::item_in_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output i2cms_pkg::item_out_t out_item_o
);

  i2cms_pkg::dp_cmd_t  cmd;
  i2cms_pkg::dp_stat_t stat;

  i2cms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  i2cms_datapath #(
    .MAX_MESSAGES (MAX_MESSAGES),
    .PAYLOAD_AW   (PAYLOAD_AW),
    .CHANNELS     (CHANNELS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule

>>> tb/sv/i2c_message_sequencer_checker.sv
module i2c_message_sequencer_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  i2cms_pkg::item_in_t  in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  i2cms_pkg::item_out_t out_item_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output logic                 xfer_busy_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import i2cms_pkg::*;

  localparam int MSGS  = MAX_MESSAGES_DEF;
  localparam int BYTES = 1 << PAYLOAD_AW_DEF;
  localparam int CHANS = CHANNELS_DEF;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_START, SEQ_WRITE, SEQ_READ} seq_phase_e;

  logic [6:0] msg_addr[MSGS];
  logic [2:0] msg_flags[MSGS];
  int         msg_len[MSGS];
  int         msg_off[MSGS];
  logic [7:0] payload[BYTES];
  int         n_loaded, load_ptr, cur_msg, left, byte_ptr;
  logic [1:0] chan_q;
  seq_phase_e phase;

  item_out_t  expected_q[$];
  int         fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic int cur_idx();
    return (cur_msg < MSGS) ? cur_msg : 0;
  endfunction

  function automatic void finish_xfer(inout item_out_t r, input logic [1:0] st);
    r.end_status    = st;
    r.messages_done = 4'(n_loaded - left);
    phase    = SEQ_IDLE;
    n_loaded = 0;
    load_ptr = 0;
    cur_msg  = 0;
    left     = 0;
    byte_ptr = 0;
  endfunction

  function automatic void put_cmd(inout item_out_t r, input bit rd, input logic [7:0] tx);
    int m;
    m = cur_idx();
    r.issue_command  = 1'b1;
    r.send_start     = (phase == SEQ_START);
    r.direction_read = rd;
    r.ack_enable     = rd && !msg_flags[m][2];
    r.send_stop      = (byte_ptr == msg_len[m]);
    r.bus_channel    = chan_q;
    r.transmit_byte  = rd ? 8'h00 : tx;
  endfunction

  function automatic void put_start(inout item_out_t r);
    int m;
    m = cur_idx();
    phase = SEQ_START;
    put_cmd(r, 1'b0, {msg_addr[m], msg_flags[m][0]});
  endfunction

  function automatic bit advance_msg(inout item_out_t r);
    byte_ptr = 0;
    cur_msg++;
    if (left > 0) left--;
    if (left == 0) begin
      finish_xfer(r, END_STOP);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // shared tail of read and write paths; wr selects the path
  function automatic void continue_xfer(inout item_out_t r, input bit wr);
    int m;
    while (1) begin
      m = cur_idx();
      if (byte_ptr != msg_len[m]) begin
        if (wr) begin
          logic [7:0] b;
          b = payload[(msg_off[m] + byte_ptr) % BYTES];
          byte_ptr++;
          put_cmd(r, 1'b0, b);
        end else begin
          put_cmd(r, 1'b1, 8'h00);
        end
        return;
      end
      if (advance_msg(r)) return;
      m = cur_idx();
      if (!msg_flags[m][1]) begin
        put_start(r);
        return;
      end
      // no-start message of the other direction ends the transfer
      if (msg_flags[m][0] == wr) begin
        finish_xfer(r, END_STOP);
        return;
      end
    end
  endfunction

  function automatic item_out_t sequence_step(item_in_t it);
    item_out_t r;
    int        pos;
    r = '0;
    case (it.operation)
      OP_LOAD_MSG: begin
        if (phase == SEQ_IDLE && n_loaded < MSGS) begin
          msg_addr[n_loaded]  = it.target_address;
          msg_flags[n_loaded] = {it.no_read_ack_flag, it.no_start_flag, it.read_flag};
          msg_len[n_loaded]   = it.length;
          msg_off[n_loaded]   = load_ptr;
          if (it.read_flag) load_ptr = (load_ptr + it.length) % BYTES;
          n_loaded++;
        end
      end
      OP_LOAD_BYTE: begin
        if (phase == SEQ_IDLE) begin
          payload[load_ptr] = it.data_byte;
          load_ptr = (load_ptr + 1) % BYTES;
        end
      end
      OP_BEGIN: begin
        if (phase == SEQ_IDLE) begin
          cur_msg  = 0;
          byte_ptr = 0;
          if (int'(it.channel) >= CHANS) begin
            left = n_loaded;
            finish_xfer(r, END_ABORT);
            r.messages_done = '0;
          end else if (n_loaded == 0) begin
            left = 0;
            finish_xfer(r, END_STOP);
          end else begin
            chan_q = it.channel;
            left   = n_loaded;
            put_start(r);
          end
        end
      end
      OP_BYTE_DONE: begin
        if (phase == SEQ_START) begin
          if (msg_flags[cur_idx()][0]) begin
            phase = SEQ_READ;
            continue_xfer(r, 1'b0);
          end else begin
            phase = SEQ_WRITE;
            continue_xfer(r, 1'b1);
          end
        end else if (phase == SEQ_WRITE) begin
          continue_xfer(r, 1'b1);
        end else if (phase == SEQ_READ) begin
          pos = (msg_off[cur_idx()] + byte_ptr) % BYTES;
          payload[pos]       = it.data_byte;
          r.capture_valid    = 1'b1;
          r.capture_byte     = it.data_byte;
          r.capture_position = 8'(pos);
          byte_ptr++;
          continue_xfer(r, 1'b0);
        end
      end
      OP_BUS_ERROR: begin
        if (phase != SEQ_IDLE) finish_xfer(r, END_ABORT);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    item_out_t e;
    item_out_t a;
    if (!rst_ni) begin
      n_loaded    = 0;
      load_ptr    = 0;
      cur_msg     = 0;
      left        = 0;
      byte_ptr    = 0;
      chan_q      = '0;
      phase       = SEQ_IDLE;
      xfer_busy_o <= 1'b0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        a = out_item_i;
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected");
          fails++;
        end else begin
          e = expected_q.pop_front();
          check_field("issue_command", e.issue_command, a.issue_command);
          check_field("send_start", e.send_start, a.send_start);
          check_field("send_stop", e.send_stop, a.send_stop);
          check_field("direction_read", e.direction_read, a.direction_read);
          check_field("ack_enable", e.ack_enable, a.ack_enable);
          check_field("bus_channel", e.bus_channel, a.bus_channel);
          check_field("transmit_byte", e.transmit_byte, a.transmit_byte);
          check_field("capture_valid", e.capture_valid, a.capture_valid);
          check_field("capture_byte", e.capture_byte, a.capture_byte);
          check_field("capture_position", e.capture_position, a.capture_position);
          check_field("end_status", e.end_status, a.end_status);
          check_field("messages_done", e.messages_done, a.messages_done);
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(sequence_step(in_item_i));
      xfer_busy_o <= (phase != SEQ_IDLE);
    end
  end

endmodule

>>> tb/sv/tb_i2c_message_sequencer.sv
module tb_i2c_message_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cms_pkg::*;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int         STALL_LIMIT  = 20000;
  localparam int         LONG_HOLD    = 400;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  item_in_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  item_out_t out_item;

  int   fails, pending, sent, idle_cycles;
  logic busy;
  bit   no_idle, hold_req;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  i2c_message_sequencer u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item)
  );

  i2c_message_sequencer_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_item_i(out_item),
    .fail_count_o(fails), .pending_o(pending), .xfer_busy_o(busy)
  );

  function automatic int draw_gap();
    return no_idle ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0);
  endfunction

  // leaves valid high at the accepting edge so the next item can follow at once
  task automatic send(item_in_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall);
    sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    settle();
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic item_in_t mk(logic [2:0] op);
    item_in_t it;
    it = $bits(item_in_t)'($urandom);
    it.operation = op;
    return it;
  endfunction

  function automatic item_in_t mk_msg(logic [6:0] a, bit rd, bit ns, bit na, logic [7:0] len);
    item_in_t it;
    it = mk(OP_LOAD_MSG);
    it.target_address   = a;
    it.read_flag        = rd;
    it.no_start_flag    = ns;
    it.no_read_ack_flag = na;
    it.length           = len;
    return it;
  endfunction

  task automatic load_msg(item_in_t m);
    item_in_t b;
    send(m);
    if (!m.read_flag) begin
      for (int i = 0; i < m.length; i++) begin
        b = mk(OP_LOAD_BYTE);
        send(b);
      end
    end
  endtask

  task automatic begin_xfer(logic [1:0] ch);
    item_in_t it;
    it = mk(OP_BEGIN);
    it.channel = ch;
    send(it);
    settle();
  endtask

  // clock byte-done items until the transfer ends, with occasional faults and noise if faults is set
  task automatic run_bytes(bit faults);
    int r;
    while (busy) begin
      r = $urandom_range(0, 99);
      if (faults && r < 2) send(mk(OP_BUS_ERROR));
      else if (faults && r < 4) send(mk(OP_LOAD_MSG));
      else if (faults && r < 5) send(mk(OP_BEGIN));
      else if (faults && r < 6) send(mk(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI))));
      else send(mk(OP_BYTE_DONE));
      settle();
    end
  endtask

  task automatic random_transfer();
    int       n;
    item_in_t m;
    logic [7:0] len;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 59))
        0:       len = 8'd255;
        1, 2:    len = 8'($urandom_range(100, 200));
        3, 4, 5: len = 8'($urandom_range(5, 30));
        default: len = 8'($urandom_range(0, 4));
      endcase
      m = mk_msg(7'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), len);
      load_msg(m);
      if ($urandom_range(0, 9) == 0) send(mk(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI))));
      if ($urandom_range(0, 14) == 0) send(mk(OP_BYTE_DONE));
      if ($urandom_range(0, 14) == 0) send(mk(OP_BUS_ERROR));
    end
    begin_xfer(2'($urandom));
    run_bytes(1'b1);
  endtask

  // receiver: per-item stall draw, plus one long hold on request
  initial begin
    int w;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !held) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        held = 1'b1;
      end
      w = draw_gap();
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid && !(hold_req && !held));
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("i2c_message_sequencer verification failed");
      $finish;
    end
  end

  initial begin
    item_in_t it;
    sent = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole payload ram while results pile up behind a long hold
    hold_req = 1'b1;
    for (int i = 0; i < 256; i++) begin
      it = mk(OP_LOAD_BYTE);
      it.data_byte = (i == 0) ? 8'h00 : (i == 1) ? 8'hff : 8'($urandom);
      send(it);
    end
    drain();

    // empty list, then idle events and unused codes
    begin_xfer(2'd0);
    send(mk(OP_BYTE_DONE));
    send(mk(OP_BUS_ERROR));
    for (logic [3:0] op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++) send(mk(op[2:0]));
    settle();

    // zero-length write then zero-length read, restart between
    load_msg(mk_msg(7'h00, 1'b0, 1'b0, 1'b0, 8'd0));
    load_msg(mk_msg(7'h7f, 1'b1, 1'b0, 1'b0, 8'd0));
    begin_xfer(2'd1);
    run_bytes(1'b0);

    // write then no-start write, then no-start read after a write
    load_msg(mk_msg(7'h2a, 1'b0, 1'b0, 1'b0, 8'd2));
    load_msg(mk_msg(7'h2a, 1'b0, 1'b1, 1'b0, 8'd1));
    load_msg(mk_msg(7'h2a, 1'b1, 1'b1, 1'b1, 8'd2));
    begin_xfer(2'd2);
    run_bytes(1'b0);

    // read without ack, no-start read follows; begin and load while running
    load_msg(mk_msg(7'h55, 1'b1, 1'b0, 1'b1, 8'd2));
    load_msg(mk_msg(7'h55, 1'b1, 1'b1, 1'b0, 8'd1));
    begin_xfer(2'd3);
    send(mk(OP_BEGIN));
    send(mk(OP_LOAD_MSG));
    send(mk(OP_LOAD_BYTE));
    settle();
    run_bytes(1'b0);

    // list overflow, then bus error in flight
    for (int i = 0; i < 9; i++) load_msg(mk_msg(7'($urandom), 1'b1, 1'b0, 1'b0, 8'd1));
    begin_xfer(2'd0);
    send(mk(OP_BYTE_DONE));
    send(mk(OP_BUS_ERROR));
    settle();

    // longest write, 255 payload bytes
    load_msg(mk_msg(7'h11, 1'b0, 1'b0, 1'b0, 8'd255));
    begin_xfer(2'd1);
    run_bytes(1'b0);
    drain();

    while (sent < 1000) begin
      if ($urandom_range(0, 19) == 0) begin
        drain();
        no_idle = ~no_idle;
      end
      random_transfer();
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("i2c_message_sequencer verification clean");
    end else begin
      $display("i2c_message_sequencer verification failed");
    end
    $finish;
  end
endmodule
